// File: rtl/skt_pkg.sv
// Shared types and constants for the sorted key table.
// Holds the operation and status codes, the controller state and command types.
// No dependencies.
package skt_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int DEFAULT_KEY_BITS = 16;
    localparam int KIND_BITS        = 2;
    localparam int STATUS_BITS      = 2;
    localparam int FIELD_BITS       = 5;
    localparam int OUT_DATA_BITS    = 16;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_SEARCH = 2'd2
    } kind_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic compare;
        logic commit;
    } cmd_t;

endpackage

// File: rtl/skt_ctrl.sv
// Controller of the sorted key table: sequences capture, compare and commit.
// Depends on skt_pkg for the state and command types.
module skt_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output skt_pkg::cmd_t  cmd
);
    import skt_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        out_free    = !out_valid_reg || out_ready;
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_COMPARE;
                end
            end
            ST_COMPARE:
            begin
                cmd.compare = 1'b1;
                state_next  = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    in_ready   = 1'b1;
                    if (in_valid)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = ST_COMPARE;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: rtl/skt_datapath.sv
// Datapath of the sorted key table: a chain of key cells with per-cell compare and shift.
// Holds the entry count and the result register. Depends on skt_pkg.
module skt_datapath
#(
    parameter int CAPACITY = skt_pkg::DEFAULT_CAPACITY,
    parameter int KEY_BITS = skt_pkg::DEFAULT_KEY_BITS
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  skt_pkg::cmd_t                       cmd,
    input  logic [skt_pkg::KIND_BITS-1:0]       kind,
    input  logic signed [KEY_BITS-1:0]          key,
    output skt_pkg::status_t                    status,
    output logic [skt_pkg::FIELD_BITS-1:0]      position,
    output logic [skt_pkg::FIELD_BITS-1:0]      entry_count
);
    import skt_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int EXT_W = (CNT_W > FIELD_BITS) ? CNT_W : FIELD_BITS;

    logic signed [KEY_BITS-1:0] keys_reg [CAPACITY];
    logic signed [KEY_BITS-1:0] keys_next [CAPACITY];
    logic signed [KEY_BITS-1:0] shift_dn [CAPACITY];
    logic signed [KEY_BITS-1:0] shift_up [CAPACITY];
    logic signed [KEY_BITS-1:0] key_reg;
    logic [KIND_BITS-1:0]       kind_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [CNT_W-1:0]           cnt_next;
    logic [CAPACITY-1:0]        below_reg;
    logic [CAPACITY-1:0]        below_next;
    logic [CAPACITY-1:0]        prev_below;
    logic                       hit_reg;
    logic                       hit_next;
    logic [CAPACITY-1:0]        live;
    logic [CAPACITY-1:0]        match;
    logic [CNT_W-1:0]           pos;
    logic [CNT_W-1:0]           pos_result;
    logic                       is_insert;
    logic                       is_delete;
    logic                       full;
    status_t                    status_next;
    logic [EXT_W-1:0]           pos_ext;
    logic [EXT_W-1:0]           cnt_ext;
    status_t                    status_reg;
    logic [FIELD_BITS-1:0]      position_reg;
    logic [FIELD_BITS-1:0]      entry_count_reg;

    always_comb
    begin
        is_insert = (kind_reg == KIND_INSERT);
        is_delete = (kind_reg == KIND_DELETE);
        full      = (cnt_reg == CNT_W'(CAPACITY));
    end

    // A cell holds a key when its index lies below the count.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            live[i]       = (CNT_W'(i) < cnt_reg);
            match[i]      = live[i] && (keys_reg[i] == key_reg);
            below_next[i] = live[i] && (keys_reg[i] < key_reg);
        end
        // An equal key at the lowest position pushes the insert one place up.
        below_next[0] = below_next[0] || (is_insert && match[0]);
        hit_next      = |match;
    end

    // The flags form a thermometer code; its first clear bit is the position.
    always_comb
    begin
        prev_below = {below_reg[CAPACITY-2:0], 1'b1};
        pos        = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (!below_reg[i] && prev_below[i])
            begin
                pos = pos | CNT_W'(i);
            end
        end
        if (below_reg[CAPACITY-1])
        begin
            pos = CNT_W'(CAPACITY);
        end
    end

    always_comb
    begin
        shift_dn[0]          = key_reg;
        shift_up[CAPACITY-1] = keys_reg[CAPACITY-1];
        for (int i = 1; i < CAPACITY; i++)
        begin
            shift_dn[i]   = keys_reg[i-1];
            shift_up[i-1] = keys_reg[i];
        end
    end

    always_comb
    begin
        keys_next   = keys_reg;
        cnt_next    = cnt_reg;
        status_next = STATUS_OK;
        pos_result  = pos;
        if (is_insert)
        begin
            if (full)
            begin
                status_next = STATUS_FULL;
                pos_result  = '0;
            end
            else
            begin
                for (int i = 0; i < CAPACITY; i++)
                begin
                    if (!below_reg[i])
                    begin
                        keys_next[i] = prev_below[i] ? key_reg : shift_dn[i];
                    end
                end
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
        else if (!hit_reg)
        begin
            status_next = STATUS_NOT_FOUND;
            pos_result  = '0;
        end
        else if (is_delete)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (!below_reg[i])
                begin
                    keys_next[i] = shift_up[i];
                end
            end
            cnt_next = cnt_reg - CNT_W'(1);
        end
        pos_ext = EXT_W'(pos_result);
        cnt_ext = EXT_W'(cnt_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.commit)
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            key_reg  <= key;
            kind_reg <= kind;
        end
        if (cmd.compare)
        begin
            below_reg <= below_next;
            hit_reg   <= hit_next;
        end
        if (cmd.commit)
        begin
            keys_reg        <= keys_next;
            status_reg      <= status_next;
            position_reg    <= pos_ext[FIELD_BITS-1:0];
            entry_count_reg <= cnt_ext[FIELD_BITS-1:0];
        end
    end

    assign status      = status_reg;
    assign position    = position_reg;
    assign entry_count = entry_count_reg;

endmodule

// File: rtl/sorted_key_table.sv
// Sorted key table: up to CAPACITY signed keys kept in ascending order.
// A word is accepted and compared in the next cycle; its result is registered when the
// commit step finds the output free, and m_tvalid then rises. The next word can be
// accepted at that commit, so one word at a time passes the compare and the shift of
// the key cell chain. Reset clears the entry count and the result valid; key cells are
// not cleared. Depends on skt_pkg, skt_ctrl and skt_datapath.
module sorted_key_table
#(
    parameter int CAPACITY = skt_pkg::DEFAULT_CAPACITY,
    parameter int KEY_BITS = skt_pkg::DEFAULT_KEY_BITS
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0: key.
    input  logic [((KEY_BITS + 7) / 8) * 8-1:0] s_tdata,
    // Fields from bit 0: kind.
    input  logic [skt_pkg::KIND_BITS-1:0]       s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // Fields from bit 0: position, entry_count.
    output logic [skt_pkg::OUT_DATA_BITS-1:0]   m_tdata,
    // Fields from bit 0: status.
    output logic [skt_pkg::STATUS_BITS-1:0]     m_tuser
);
    import skt_pkg::*;

    cmd_t                  cmd;
    status_t               status;
    logic [FIELD_BITS-1:0] position;
    logic [FIELD_BITS-1:0] entry_count;

    skt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd)
    );

    skt_datapath
    #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .kind        (s_tuser),
        .key         ($signed(s_tdata[KEY_BITS-1:0])),
        .status      (status),
        .position    (position),
        .entry_count (entry_count)
    );

    assign m_tuser = status;
    assign m_tdata = {{(OUT_DATA_BITS - 2 * FIELD_BITS){1'b0}}, entry_count, position};

    // Only one word is in flight, so the port closes right after an acceptance.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while a word is still in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |-> ##3 m_tvalid)
    else $error("no result after an accepted word");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == STATUS_FULL || m_tuser == STATUS_NOT_FOUND))
            |-> (m_tdata[FIELD_BITS-1:0] == '0))
    else $error("failed operation reports a non-zero position");

endmodule

// File: tb/tb.sv
// Testbench of sorted_key_table: sends insert, delete, search and spare words; checks each result.
// A scoreboard class keeps its own ordered copy of the table to predict every result word.
// Depends on skt_pkg and sorted_key_table.
`timescale 1ns / 1ps

module tb;

    import skt_pkg::*;

    localparam int CAPACITY     = 16;
    localparam int KEY_BITS     = 16;
    localparam int RANDOM_WORDS = 580;
    localparam int PHASE_WORDS  = 40;
    localparam logic [KIND_BITS-1:0] KIND_SPARE = 2'd3;

    localparam int STYLE_FILL  = 0;
    localparam int STYLE_MIXED = 1;
    localparam int STYLE_DRAIN = 2;

    localparam int RX_OPEN    = 0;
    localparam int RX_CHOPPY  = 1;
    localparam int RX_CHOKED  = 2;

    typedef struct {
        status_t        status;
        logic [4:0]     position;
        logic [4:0]     count;
    } reply_t;

    class key_order_tracker;
        logic signed [KEY_BITS-1:0] held_keys [CAPACITY];
        int                         held;
        reply_t                     pending_replies [$];
        int                         faults;
        int                         inserts;
        int                         deletes;
        int                         searches;
        int                         refusals;
        int                         misses;
        int                         peak;

        function void note_word(logic [KIND_BITS-1:0] kind, logic signed [KEY_BITS-1:0] key);
            reply_t r;
            int     slot;
            int     hit;
            int     i;
            r.status = STATUS_OK;
            slot = 0;
            if (kind == KIND_INSERT)
            begin
                inserts++;
                if (held >= CAPACITY)
                begin
                    r.status = STATUS_FULL;
                    refusals++;
                end
                else
                begin
                    while (slot < held && held_keys[slot] < key)
                        slot++;
                    if (slot == 0 && held > 0 && held_keys[0] == key)
                        slot = 1;
                    for (i = held; i > slot; i--)
                        held_keys[i] = held_keys[i-1];
                    held_keys[slot] = key;
                    held++;
                end
            end
            else
            begin
                if (kind == KIND_DELETE)
                    deletes++;
                else
                    searches++;
                hit = -1;
                for (i = 0; i < held; i++)
                begin
                    if (hit < 0 && held_keys[i] == key)
                        hit = i;
                end
                if (hit < 0)
                begin
                    r.status = STATUS_NOT_FOUND;
                    misses++;
                end
                else
                begin
                    slot = hit;
                    if (kind == KIND_DELETE)
                    begin
                        for (i = hit; i + 1 < held; i++)
                            held_keys[i] = held_keys[i+1];
                        held--;
                    end
                end
            end
            if (held > peak)
                peak = held;
            r.position = slot[4:0];
            r.count    = held[4:0];
            pending_replies.push_back(r);
        endfunction

        function void check_word(logic [1:0] status, logic [4:0] position, logic [4:0] count);
            reply_t exp;
            if (pending_replies.size() == 0)
            begin
                $error("result word arrived with nothing expected");
                faults++;
                return;
            end
            exp = pending_replies.pop_front();
            if (status !== exp.status)
            begin
                $error("status: expected %0d, got %0d", exp.status, status);
                faults++;
            end
            if (position !== exp.position)
            begin
                $error("position: expected %0d, got %0d", exp.position, position);
                faults++;
            end
            if (count !== exp.count)
            begin
                $error("entry_count: expected %0d, got %0d", exp.count, count);
                faults++;
            end
        endfunction
    endclass

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [15:0]            s_tdata  = '0;
    logic [KIND_BITS-1:0]   s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic [STATUS_BITS-1:0] m_tuser;

    key_order_tracker tracker = new;

    int burst_left = 0;
    int rx_style   = RX_OPEN;
    int rx_left    = 0;

    sorted_key_table #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("[sorted_key_table] ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_word(m_tuser, m_tdata[4:0], m_tdata[9:5]);
    end

    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_style = $urandom_range(2, 0);
            rx_left  = $urandom_range(60, 5);
        end
        rx_left--;
        case (rx_style)
            RX_CHOPPY: m_tready <= 1'($urandom_range(1, 0));
            RX_CHOKED: m_tready <= ($urandom_range(4, 0) == 0);
            default:   m_tready <= 1'b1;
        endcase
    end

    task automatic send_word(input logic [KIND_BITS-1:0] kind,
                             input int key_value);
        logic signed [KEY_BITS-1:0] key;
        int                         gap;
        key = KEY_BITS'(key_value);
        s_tvalid <= 1'b1;
        s_tdata  <= key;
        s_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_tready);
        tracker.note_word(kind, key);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = $urandom_range(8, 1);
            burst_left = ($urandom_range(5, 0) == 0) ? $urandom_range(80, 30)
                                                     : $urandom_range(12, 0);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic int pick_key(input logic [KIND_BITS-1:0] kind);
        int sel;
        sel = $urandom_range(99, 0);
        if (kind != KIND_INSERT && tracker.held > 0 && sel < 65)
            return int'(tracker.held_keys[$urandom_range(tracker.held - 1, 0)]);
        sel = $urandom_range(2, 0);
        if (sel == 0)
            return int'($urandom_range(6, 0)) - 3;
        if (sel == 1)
        begin
            case ($urandom_range(5, 0))
                0: return -32768;
                1: return -32767;
                2: return 32767;
                3: return 32766;
                4: return -1;
                default: return 0;
            endcase
        end
        return int'($urandom_range(65535, 0)) - 32768;
    endfunction

    function automatic logic [KIND_BITS-1:0] pick_kind(input int style);
        int roll;
        roll = $urandom_range(99, 0);
        if (roll < 4)
            return KIND_SPARE;
        case (style)
            STYLE_MIXED: return (roll < 38) ? KIND_INSERT : (roll < 68) ? KIND_DELETE : KIND_SEARCH;
            STYLE_DRAIN: return (roll < 18) ? KIND_INSERT : (roll < 80) ? KIND_DELETE : KIND_SEARCH;
            default:     return (roll < 72) ? KIND_INSERT : (roll < 86) ? KIND_DELETE : KIND_SEARCH;
        endcase
    endfunction

    initial
    begin
        int                         n;
        int                         style;
        int                         drain_wait;
        logic [KIND_BITS-1:0]       kind;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Lookups on an empty table, then the extremes, duplicates and the spare kind.
        send_word(KIND_SEARCH, 0);
        send_word(KIND_DELETE, 5);
        send_word(KIND_INSERT, 0);
        send_word(KIND_INSERT, -32768);
        send_word(KIND_INSERT, 32767);
        send_word(KIND_INSERT, -32768);
        send_word(KIND_INSERT, 0);
        send_word(KIND_SEARCH, 0);
        send_word(KIND_SPARE, 32767);
        send_word(KIND_SPARE, -32767);
        send_word(KIND_SEARCH, -32767);
        send_word(KIND_DELETE, -32768);
        send_word(KIND_DELETE, 32767);
        send_word(KIND_DELETE, 12345);
        send_word(KIND_INSERT, -1);
        send_word(KIND_INSERT, 32767);
        send_word(KIND_SEARCH, -1);

        style = STYLE_FILL;
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n > 0 && n % PHASE_WORDS == 0)
                style = $urandom_range(2, 0);
            kind = pick_kind(style);
            send_word(kind, pick_key(kind));
        end
        s_tvalid <= 1'b0;

        drain_wait = 0;
        while (tracker.pending_replies.size() != 0 && drain_wait < 20000)
        begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (12) @(posedge clk);

        $display("Covered %0d inserts (%0d refused as full), %0d deletes and %0d searches,",
                 tracker.inserts, tracker.refusals, tracker.deletes, tracker.searches);
        $display("with %0d lookups missing and the table filled to at most %0d keys.",
                 tracker.misses, tracker.peak);
        if (tracker.faults == 0 && tracker.pending_replies.size() == 0)
            $display("[sorted_key_table] OK");
        else
            $display("[sorted_key_table] ERROR");
        $finish;
    end

endmodule
